// ===== rtl/oaat_hb_pkg.sv =====
`timescale 1ns / 1ps

package oaat_hb_pkg;

  localparam int unsigned HASH_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 25;
  localparam int unsigned ITER_W  = $clog2(HASH_W);

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4096);

  // Shift amounts of the byte mix and the final mix
  localparam int unsigned SHAMT_W  = 4;
  localparam logic [SHAMT_W-1:0] MIX_SHL  = SHAMT_W'(10);
  localparam logic [SHAMT_W-1:0] MIX_SHR  = SHAMT_W'(6);
  localparam logic [SHAMT_W-1:0] FIN_SHL1 = SHAMT_W'(3);
  localparam logic [SHAMT_W-1:0] FIN_SHR  = SHAMT_W'(11);
  localparam logic [SHAMT_W-1:0] FIN_SHL2 = SHAMT_W'(15);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MIX1 = 9'b000000010,
    S_MIX2 = 9'b000000100,
    S_MIX3 = 9'b000001000,
    S_FIN1 = 9'b000010000,
    S_FIN2 = 9'b000100000,
    S_FIN3 = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

endpackage

// ===== rtl/one_at_a_time_hash_bucket.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Payload (low bit first)                 Request taken when
// in       slave      tdata: key_byte[7:0]; tuser: has_byte;   in_tvalid & in_tready
//                     tlast: last
// out      master     tdata: bucket_index[31:0]                out_tvalid & out_tready
// cfg      slave      cfg_data: bucket_count[24:0]             cfg_valid & cfg_ready
//
// A byte request is accepted, then takes three passes through the shared add/xor unit.
// A request marked last adds 3 final-mix passes, a one-bit-a-cycle restoring remainder
// over the 32 dividend bits when bucket_count is nonzero, and a load of the output register.
// An idle request is only accepted and leaves the block idle.
// Reset (rst_n low, synchronous) clears hash, sequencer and output valid; count is 4096.
// in_tready is low while a request is in work; a waiting result holds only the next one.

module one_at_a_time_hash_bucket (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [oaat_hb_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] key_byte
  input  logic                               in_tuser,   // [0] has_byte
  input  logic                               in_tlast,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [oaat_hb_pkg::HASH_W-1:0]     out_tdata,  // [31:0] bucket_index
  // configuration write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [oaat_hb_pkg::COUNT_W-1:0]    cfg_data    // [24:0] bucket_count
);

  localparam int unsigned HW = oaat_hb_pkg::HASH_W;
  localparam int unsigned CW = oaat_hb_pkg::COUNT_W;
  localparam int unsigned IW = oaat_hb_pkg::ITER_W;
  localparam int unsigned SW = oaat_hb_pkg::SHAMT_W;

  oaat_hb_pkg::state_t state_r, state_nxt;

  logic [HW-1:0]                  hash_r, hash_nxt;
  logic [oaat_hb_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic                           last_r, last_nxt;
  logic [CW-1:0]                  count_r;
  logic [HW-1:0]                  dvd_r, dvd_nxt;
  logic [CW-1:0]                  rem_r, rem_nxt;
  logic [IW-1:0]                  iter_r, iter_nxt;
  logic [HW-1:0]                  res_r, res_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [HW-1:0]                  out_data_r, out_data_nxt;

  // shared mixing unit
  logic [SW-1:0] shamt;
  logic          use_byte;
  logic [HW-1:0] addend;
  logic [HW-1:0] alu_add;
  logic [HW-1:0] alu_xor;

  // remainder step
  logic [CW:0]   rem_shift;
  logic [CW:0]   rem_diff;
  logic          rem_ge;

  logic in_acc;

  assign in_tready  = (state_r == oaat_hb_pkg::S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Pick the shift amount and addend for the current pass
  always_comb begin
    shamt    = oaat_hb_pkg::MIX_SHL;
    use_byte = 1'b0;
    unique case (state_r)
      oaat_hb_pkg::S_MIX1: use_byte = 1'b1;
      oaat_hb_pkg::S_MIX2: shamt = oaat_hb_pkg::MIX_SHL;
      oaat_hb_pkg::S_MIX3: shamt = oaat_hb_pkg::MIX_SHR;
      oaat_hb_pkg::S_FIN1: shamt = oaat_hb_pkg::FIN_SHL1;
      oaat_hb_pkg::S_FIN2: shamt = oaat_hb_pkg::FIN_SHR;
      oaat_hb_pkg::S_FIN3: shamt = oaat_hb_pkg::FIN_SHL2;
      default:             shamt = oaat_hb_pkg::MIX_SHL;
    endcase
  end

  assign addend  = use_byte ? {{(HW - oaat_hb_pkg::BYTE_W){1'b0}}, byte_r} : (hash_r << shamt);
  assign alu_add = hash_r + addend;
  assign alu_xor = hash_r ^ (hash_r >> shamt);

  // One restoring step: bring in the next dividend bit, subtract if it fits
  assign rem_shift = {rem_r, dvd_r[HW-1]};
  assign rem_diff  = rem_shift - {1'b0, count_r};
  assign rem_ge    = (rem_shift >= {1'b0, count_r});

  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    iter_nxt      = iter_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // drop the held result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      oaat_hb_pkg::S_IDLE: begin
        if (in_acc) begin
          byte_nxt = in_tdata;
          last_nxt = in_tlast;
          if (in_tuser) begin
            state_nxt = oaat_hb_pkg::S_MIX1;
          end else if (in_tlast) begin
            state_nxt = oaat_hb_pkg::S_FIN1;
          end
        end
      end
      oaat_hb_pkg::S_MIX1: begin
        hash_nxt  = alu_add;
        state_nxt = oaat_hb_pkg::S_MIX2;
      end
      oaat_hb_pkg::S_MIX2: begin
        hash_nxt  = alu_add;
        state_nxt = oaat_hb_pkg::S_MIX3;
      end
      oaat_hb_pkg::S_MIX3: begin
        hash_nxt  = alu_xor;
        state_nxt = last_r ? oaat_hb_pkg::S_FIN1 : oaat_hb_pkg::S_IDLE;
      end
      oaat_hb_pkg::S_FIN1: begin
        hash_nxt  = alu_add;
        state_nxt = oaat_hb_pkg::S_FIN2;
      end
      oaat_hb_pkg::S_FIN2: begin
        hash_nxt  = alu_xor;
        state_nxt = oaat_hb_pkg::S_FIN3;
      end
      oaat_hb_pkg::S_FIN3: begin
        // final value leaves the running hash, which restarts at zero
        hash_nxt = '0;
        dvd_nxt  = alu_add;
        res_nxt  = alu_add;
        rem_nxt  = '0;
        iter_nxt = '0;
        state_nxt = (count_r == '0) ? oaat_hb_pkg::S_DONE : oaat_hb_pkg::S_DIV;
      end
      oaat_hb_pkg::S_DIV: begin
        rem_nxt  = rem_ge ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
        dvd_nxt  = dvd_r << 1;
        iter_nxt = iter_r + IW'(1);
        if (iter_r == IW'(HW - 1)) begin
          res_nxt   = {{(HW - CW){1'b0}}, (rem_ge ? rem_diff[CW-1:0] : rem_shift[CW-1:0])};
          state_nxt = oaat_hb_pkg::S_DONE;
        end
      end
      oaat_hb_pkg::S_DONE: begin
        // hold until the output register is free or drains this cycle
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = oaat_hb_pkg::S_IDLE;
        end
      end
      default: state_nxt = oaat_hb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oaat_hb_pkg::S_IDLE;
      hash_r      <= '0;
      count_r     <= oaat_hb_pkg::COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    iter_r     <= iter_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== tb/tb_one_at_a_time_hash_bucket.sv =====
`timescale 1ns / 1ps

module tb_one_at_a_time_hash_bucket;

  localparam int unsigned CLK_HALF     = 5;
  // Slowest run: about 1100 requests, each with the longest input gap, the mix
  // passes, the final mix and remainder and the longest output stall, plus
  // the config pauses. The limit allows four times that.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Drain time after the last byte, covering the final mix, remainder and output load.
  localparam int unsigned DRAIN_CYCLES = 50;

  localparam logic [oaat_hb_pkg::COUNT_W-1:0] COUNT_MAX = {oaat_hb_pkg::COUNT_W{1'b1}};
  localparam logic [oaat_hb_pkg::COUNT_W-1:0] COUNT_TOP = oaat_hb_pkg::COUNT_W'(16777216);

  logic                                clk        = 1'b0;
  logic                                rst_n      = 1'b0;
  logic                                in_tvalid  = 1'b0;
  logic                                in_tready;
  logic [oaat_hb_pkg::BYTE_W-1:0]      in_tdata   = '0;    // [7:0] key_byte
  logic                                in_tuser   = 1'b0;  // [0] has_byte
  logic                                in_tlast   = 1'b0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [oaat_hb_pkg::HASH_W-1:0]      out_tdata;          // [31:0] bucket_index
  logic                                cfg_valid  = 1'b0;
  logic                                cfg_ready;
  logic [oaat_hb_pkg::COUNT_W-1:0]     cfg_data   = '0;    // [24:0] bucket_count

  // Predictor state: the running hash and the table size as the block holds them
  logic [oaat_hb_pkg::HASH_W-1:0]      hash_acc   = '0;
  logic [oaat_hb_pkg::COUNT_W-1:0]     table_size = oaat_hb_pkg::COUNT_RESET;
  // Bucket indexes predicted but not yet seen on the result stream, oldest first
  logic [oaat_hb_pkg::HASH_W-1:0]      bucket_queue[$];
  logic [oaat_hb_pkg::HASH_W-1:0]      want_bucket;

  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count    = 0;
  // Set for the closing part of the run: no gaps on input, no stalls on output
  bit                  calm           = 1'b0;

  one_at_a_time_hash_bucket dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Hash arithmetic, all modulo 2^32
  // ---------------------------------------------------------------------------

  // Fold one key byte into the running value
  function automatic logic [oaat_hb_pkg::HASH_W-1:0] mix_key_byte(
      input logic [oaat_hb_pkg::HASH_W-1:0] h,
      input logic [oaat_hb_pkg::BYTE_W-1:0] b);
    logic [oaat_hb_pkg::HASH_W-1:0] t;
    t = h + oaat_hb_pkg::HASH_W'(b);
    t = t + (t << oaat_hb_pkg::MIX_SHL);
    t = t ^ (t >> oaat_hb_pkg::MIX_SHR);
    return t;
  endfunction

  // Final avalanche applied on the request marked last
  function automatic logic [oaat_hb_pkg::HASH_W-1:0] finish_hash(
      input logic [oaat_hb_pkg::HASH_W-1:0] h);
    logic [oaat_hb_pkg::HASH_W-1:0] t;
    t = h + (h << oaat_hb_pkg::FIN_SHL1);
    t = t ^ (t >> oaat_hb_pkg::FIN_SHR);
    t = t + (t << oaat_hb_pkg::FIN_SHL2);
    return t;
  endfunction

  // A table size of zero passes the raw hash through
  function automatic logic [oaat_hb_pkg::HASH_W-1:0] reduce_to_bucket(
      input logic [oaat_hb_pkg::HASH_W-1:0]  h,
      input logic [oaat_hb_pkg::COUNT_W-1:0] n);
    if (n == '0) return h;
    return h % oaat_hb_pkg::HASH_W'(n);
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Send one request and predict its effect once it is taken. Valid stays high
  // between back-to-back requests; drop it only for a gap.
  task automatic send_key_item(input logic [oaat_hb_pkg::BYTE_W-1:0] kb, input logic hb,
                               input logic lst);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= kb;
    in_tuser  <= hb;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (hb) hash_acc = mix_key_byte(hash_acc, kb);
    if (lst) begin
      bucket_queue.push_back(reduce_to_bucket(finish_hash(hash_acc), table_size));
      hash_acc = '0;
    end
  endtask

  // Drop valid, wait until every predicted bucket has come out, then give the
  // block time to finish any request that produces no result.
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (bucket_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the table size; only done with the block idle
  task automatic write_table_size(input logic [oaat_hb_pkg::COUNT_W-1:0] n);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    table_size = n;
  endtask

  // One random key. Most keys are short runs of bytes closed by a last byte;
  // some close with a bare last request, some are empty, and idle requests
  // are sprinkled in as noise. Idle requests do not count toward the budget.
  task automatic send_random_key(inout int unsigned sent);
    int unsigned shape;
    int unsigned len;
    bit          bare_close;
    shape      = $urandom_range(0, 99);
    bare_close = (shape < 12);
    if (shape < 5)       len = 0;
    else if (shape < 90) len = $urandom_range(1, 8);
    else                 len = $urandom_range(9, 40);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_key_item(oaat_hb_pkg::BYTE_W'($urandom), 1'b0, 1'b0);
      end
      send_key_item(oaat_hb_pkg::BYTE_W'($urandom), 1'b1, !bare_close && (i == len - 1));
      sent++;
    end
    if (bare_close) begin
      send_key_item(oaat_hb_pkg::BYTE_W'($urandom), 1'b0, 1'b1);
      sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset table size of 4096: empty key straight out of reset, the byte
  // extremes, and a short multi-byte key.
  task automatic test_reset_state();
    send_key_item(8'h5a, 1'b0, 1'b1);
    send_key_item(8'h00, 1'b1, 1'b1);
    send_key_item(8'hff, 1'b1, 1'b1);
    send_key_item(8'h61, 1'b1, 1'b0);
    send_key_item(8'h62, 1'b1, 1'b0);
    send_key_item(8'h63, 1'b1, 1'b1);
  endtask

  // Idle requests inside and outside a key, and a key closed by a bare last
  task automatic test_idle_and_bare_last();
    send_key_item(8'h12, 1'b1, 1'b0);
    send_key_item(8'hff, 1'b0, 1'b0);
    send_key_item(8'h00, 1'b0, 1'b0);
    send_key_item(8'h34, 1'b1, 1'b1);
    send_key_item(8'h80, 1'b1, 1'b0);
    send_key_item(8'h7f, 1'b1, 1'b0);
    send_key_item(8'ha5, 1'b0, 1'b1);
    send_key_item(8'h3c, 1'b0, 1'b0);
  endtask

  // Raw hash, modulus of one, and the largest size the register holds
  task automatic test_count_extremes();
    write_table_size('0);
    send_key_item(8'hc3, 1'b1, 1'b0);
    send_key_item(8'h01, 1'b1, 1'b1);
    write_table_size(oaat_hb_pkg::COUNT_W'(1));
    send_key_item(8'h9e, 1'b1, 1'b1);
    write_table_size(COUNT_MAX);
    send_key_item(8'hfe, 1'b1, 1'b0);
    send_key_item(8'hef, 1'b1, 1'b1);
  endtask

  // Random keys under one table size
  task automatic test_random_keys(input int unsigned budget,
                                  input logic [oaat_hb_pkg::COUNT_W-1:0] n);
    int unsigned sent;
    sent = 0;
    write_table_size(n);
    while (sent < budget) send_random_key(sent);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, none in the calm part
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(0, 5)) @(posedge clk);
    end
  end

  // Compare every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (bucket_queue.size() == 0) begin
        $display("%0t: bucket_index with nothing pending, expected none, got %h",
                 $time, out_tdata);
        mismatch_count++;
      end else begin
        want_bucket = bucket_queue.pop_front();
        if (out_tdata !== want_bucket) begin
          $display("%0t: bucket_index mismatch, expected %h, got %h",
                   $time, want_bucket, out_tdata);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_idle_and_bare_last();
    test_count_extremes();

    test_random_keys(170, COUNT_TOP);
    test_random_keys(170, oaat_hb_pkg::COUNT_W'($urandom_range(2, int'(COUNT_MAX))));
    test_random_keys(170, '0);
    test_random_keys(170, oaat_hb_pkg::COUNT_W'($urandom_range(1, 16)));
    test_random_keys(170, oaat_hb_pkg::COUNT_RESET);

    // Close at full rate on both sides
    settle_block();
    calm = 1'b1;
    test_random_keys(170, oaat_hb_pkg::COUNT_W'($urandom_range(1, 70000)));

    settle_block();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
